// ===== rtl/core/tricubic_spline_evaluator_top_macros.svh =====
// Assertion macros for the tricubic spline evaluator checker.
// Every macro needs i_clk visible; the first two also need i_rst_n.
`ifndef TRICUBIC_SPLINE_EVALUATOR_TOP_MACROS_SVH
`define TRICUBIC_SPLINE_EVALUATOR_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define TSE_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define TSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define TSE_ASSERT_ALWAYS(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tse_pkg.sv =====
// Shared types, constants and helper functions of the tricubic spline evaluator.
// No dependencies; every other file but the macros header imports this package.
package tse_pkg;

    localparam int FRAC_BITS      = 16;
    localparam int MAX_CELLS_DEF  = 16;
    localparam int COEF_WORDS_DEF = 262144;

    localparam int POS_W     = 22;
    localparam int ADDR_IN_W = 18;
    localparam int COEF_W    = 32;
    localparam int OUT_W     = 48;
    localparam int ACC_W     = 64;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 2;

    // Powers and weights range up to one, so they need one bit above the fraction.
    localparam int PW  = FRAC_BITS + 1;
    // Coefficient times a weight scaled by up to three, as a signed product.
    localparam int PRW = COEF_W + PW + 3;

    localparam int CELL3_COEFS = 64;
    localparam int CELL2_COEFS = 16;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THREE_D = 2'd0,
        CFG_CELLS_X = 2'd1,
        CFG_CELLS_Y = 2'd2,
        CFG_CELLS_Z = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } t_op;

    // Status of the job at the head of the queue.
    typedef struct packed {
        logic valid;
        logic is_eval;
        logic wr_ok;
    } t_head;

    localparam logic signed [ACC_W-1:0] SAT_HI = (64'sd1 <<< (OUT_W - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] SAT_LO = -(64'sd1 <<< (OUT_W - 1));

    // Floor shift by the fraction width, then saturate to the output width.
    function automatic logic signed [OUT_W-1:0] finish_sum(input logic signed [ACC_W-1:0] s);
        logic signed [ACC_W-1:0] r;
        r = s >>> FRAC_BITS;
        if (r > SAT_HI) begin
            r = SAT_HI;
        end else if (r < SAT_LO) begin
            r = SAT_LO;
        end
        return r[OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/core/tse_front.sv =====
// Front end: configuration registers, coordinate clamping and cell split,
// and a short job queue toward the back end. Depends on tse_pkg.
module tse_front #(
    parameter int MAX_CELLS  = tse_pkg::MAX_CELLS_DEF,
    parameter int COEF_WORDS = tse_pkg::COEF_WORDS_DEF,
    localparam int CW = $clog2(MAX_CELLS + 1),
    localparam int AW = $clog2(COEF_WORDS)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_opcode,
    input  logic [tse_pkg::ADDR_IN_W-1:0]          i_coef_addr,
    input  logic signed [tse_pkg::COEF_W-1:0]      i_coef_value,
    input  logic signed [tse_pkg::POS_W-1:0]       i_pos_x,
    input  logic signed [tse_pkg::POS_W-1:0]       i_pos_y,
    input  logic signed [tse_pkg::POS_W-1:0]       i_pos_z,
    input  logic                                   i_cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [tse_pkg::CFG_W-1:0]              i_cfg_data,
    input  logic                                   i_pop,
    output tse_pkg::t_head                         o_head,
    output logic [AW-1:0]                          o_h_waddr,
    output logic [tse_pkg::COEF_W-1:0]             o_h_wdata,
    output logic [CW-1:0]                          o_h_xc,
    output logic [CW-1:0]                          o_h_yc,
    output logic [CW-1:0]                          o_h_zc,
    output logic [tse_pkg::FRAC_BITS-1:0]          o_h_fx,
    output logic [tse_pkg::FRAC_BITS-1:0]          o_h_fy,
    output logic [tse_pkg::FRAC_BITS-1:0]          o_h_fz,
    output logic                                   o_three,
    output logic [CW-1:0]                          o_ny,
    output logic [CW-1:0]                          o_nz
);
    import tse_pkg::*;

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW  = CW + FRAC_BITS;
    localparam int CHW = POS_W + 2 - FRAC_BITS;

    logic           r_three;
    logic [CFG_W-1:0] r_cx, r_cy, r_cz;

    logic [CW-1:0]  nx, ny, nz;
    logic [SW-1:0]  sx, sy, sz;
    logic           push;
    logic           wr_ok;

    logic [QPW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;

    logic           r_q_eval  [QUEUE_DEPTH];
    logic           r_q_wrok  [QUEUE_DEPTH];
    logic [AW-1:0]  r_q_waddr [QUEUE_DEPTH];
    logic [COEF_W-1:0] r_q_wdata [QUEUE_DEPTH];
    logic [SW-1:0]  r_q_sx    [QUEUE_DEPTH];
    logic [SW-1:0]  r_q_sy    [QUEUE_DEPTH];
    logic [SW-1:0]  r_q_sz    [QUEUE_DEPTH];

    // A cell count of zero acts as one; counts above the maximum are capped.
    function automatic logic [CW-1:0] eff_cells(input logic [CFG_W-1:0] r);
        if (r == '0) begin
            return CW'(1);
        end else if (int'(r) > MAX_CELLS) begin
            return CW'(MAX_CELLS);
        end
        return CW'(r);
    endfunction

    // Clamp to 0..cells and split into cell and fraction. At the upper edge
    // the point lands in the last cell with a zero fraction.
    function automatic logic [SW-1:0] split_pos(input logic signed [POS_W-1:0] pos,
                                                input logic [CW-1:0] cells);
        logic signed [POS_W+1:0] p;
        logic signed [POS_W+1:0] top;
        logic [POS_W+1:0]        u;
        logic [CHW-1:0]          c;
        logic [CW-1:0]           cc;
        p   = (POS_W + 2)'(pos);
        top = $signed((POS_W + 2)'(cells) << FRAC_BITS);
        if (p < 0) begin
            p = '0;
        end
        if (p > top) begin
            p = top;
        end
        u = $unsigned(p);
        c = u[POS_W+1:FRAC_BITS];
        if (c >= CHW'(cells)) begin
            cc = cells - CW'(1);
        end else begin
            cc = CW'(c);
        end
        return {cc, u[FRAC_BITS-1:0]};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three <= 1'b1;
            r_cx    <= CFG_W'(16);
            r_cy    <= CFG_W'(16);
            r_cz    <= CFG_W'(16);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_THREE_D: r_three <= i_cfg_data[0];
                CFG_CELLS_X: r_cx    <= i_cfg_data;
                CFG_CELLS_Y: r_cy    <= i_cfg_data;
                CFG_CELLS_Z: r_cz    <= i_cfg_data;
                default:     r_three <= r_three;
            endcase
        end
    end

    assign nx = eff_cells(r_cx);
    assign ny = eff_cells(r_cy);
    assign nz = r_three ? eff_cells(r_cz) : CW'(1);

    always_comb begin
        sx = split_pos(i_pos_x, nx);
        sy = split_pos(i_pos_y, ny);
        sz = r_three ? split_pos(i_pos_z, nz) : '0;
    end

    assign wr_ok   = (32'(i_coef_addr) < 32'(COEF_WORDS));
    assign o_ready = (r_cnt != QCW'(QUEUE_DEPTH));
    assign push    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPW'(1);
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_eval[r_wp]  <= (t_op'(i_opcode) == OP_EVAL);
            r_q_wrok[r_wp]  <= wr_ok;
            r_q_waddr[r_wp] <= AW'(i_coef_addr);
            r_q_wdata[r_wp] <= i_coef_value;
            r_q_sx[r_wp]    <= sx;
            r_q_sy[r_wp]    <= sy;
            r_q_sz[r_wp]    <= sz;
        end
    end

    always_comb begin
        o_head.valid   = (r_cnt != '0);
        o_head.is_eval = r_q_eval[r_rp];
        o_head.wr_ok   = r_q_wrok[r_rp];
    end

    assign o_h_waddr = r_q_waddr[r_rp];
    assign o_h_wdata = r_q_wdata[r_rp];
    assign o_h_xc    = r_q_sx[r_rp][SW-1:FRAC_BITS];
    assign o_h_yc    = r_q_sy[r_rp][SW-1:FRAC_BITS];
    assign o_h_zc    = r_q_sz[r_rp][SW-1:FRAC_BITS];
    assign o_h_fx    = r_q_sx[r_rp][FRAC_BITS-1:0];
    assign o_h_fy    = r_q_sy[r_rp][FRAC_BITS-1:0];
    assign o_h_fz    = r_q_sz[r_rp][FRAC_BITS-1:0];
    assign o_three   = r_three;
    assign o_ny      = ny;
    assign o_nz      = nz;

endmodule

// ===== rtl/core/tse_back.sv =====
// Back end: coefficient memory, power setup, the weight and multiply-accumulate
// pipeline, and the output register. Depends on tse_pkg.
module tse_back #(
    parameter int MAX_CELLS  = tse_pkg::MAX_CELLS_DEF,
    parameter int COEF_WORDS = tse_pkg::COEF_WORDS_DEF,
    localparam int CW = $clog2(MAX_CELLS + 1),
    localparam int AW = $clog2(COEF_WORDS)
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  tse_pkg::t_head                         i_head,
    input  logic [AW-1:0]                          i_h_waddr,
    input  logic [tse_pkg::COEF_W-1:0]             i_h_wdata,
    input  logic [CW-1:0]                          i_h_xc,
    input  logic [CW-1:0]                          i_h_yc,
    input  logic [CW-1:0]                          i_h_zc,
    input  logic [tse_pkg::FRAC_BITS-1:0]          i_h_fx,
    input  logic [tse_pkg::FRAC_BITS-1:0]          i_h_fy,
    input  logic [tse_pkg::FRAC_BITS-1:0]          i_h_fz,
    input  logic                                   i_three,
    input  logic [CW-1:0]                          i_ny,
    input  logic [CW-1:0]                          i_nz,
    output logic                                   o_pop,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [tse_pkg::OUT_W-1:0]       o_spline_value,
    output logic signed [tse_pkg::OUT_W-1:0]       o_grad_x,
    output logic signed [tse_pkg::OUT_W-1:0]       o_grad_y,
    output logic signed [tse_pkg::OUT_W-1:0]       o_grad_z
);
    import tse_pkg::*;

    localparam int CIW = 3 * CW;
    localparam int NW  = $clog2(CELL3_COEFS);
    localparam logic [PW-1:0] ONE = PW'(1) << FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_P2    = 6'b000010,
        S_P3    = 6'b000100,
        S_RUN   = 6'b001000,
        S_DRAIN = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state r_state;

    logic [COEF_W-1:0] mem [COEF_WORDS];
    logic [COEF_W-1:0] r_rdata;
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_addr;

    logic [CW-1:0]     r_xc, r_yc, r_zc;
    logic [PW-1:0]     r_px1, r_px2, r_px3;
    logic [PW-1:0]     r_py1, r_py2, r_py3;
    logic [PW-1:0]     r_pz1, r_pz2, r_pz3;
    logic [CIW-1:0]    r_xny, r_cidx;
    logic [NW-1:0]     r_n;
    logic [NW-1:0]     last_n;

    logic [1:0]        i0, j0, k0;
    logic              r1_v, r1_last;
    logic [1:0]        r1_i, r1_j, r1_k;
    logic [PW-1:0]     r1_pxy, r1_pxyx, r1_pxyy;

    logic              r2_v, r2_last;
    logic [1:0]        r2_i, r2_j, r2_k;
    logic [PW-1:0]     r2_w, r2_wx, r2_wy, r2_wz;
    logic [COEF_W-1:0] r2_c;

    logic              r3_v, r3_last;
    logic signed [PRW-1:0] r3_pv, r3_px, r3_py, r3_pz;

    logic signed [ACC_W-1:0] r_acc_v, r_acc_x, r_acc_y, r_acc_z;
    logic              r_out_valid;
    logic              load_out;

    // Truncating fixed-point product of two powers or weights.
    function automatic logic [PW-1:0] fmul(input logic [PW-1:0] a, input logic [PW-1:0] b);
        logic [2*PW-1:0] m;
        m = (2*PW)'(a) * (2*PW)'(b);
        return m[PW+FRAC_BITS-1:FRAC_BITS];
    endfunction

    function automatic logic [PW-1:0] pick(input logic [1:0] s, input logic [PW-1:0] a1,
                                           input logic [PW-1:0] a2, input logic [PW-1:0] a3);
        case (s)
            2'd0:    return ONE;
            2'd1:    return a1;
            2'd2:    return a2;
            2'd3:    return a3;
            default: return ONE;
        endcase
    endfunction

    // Derivative weight: the exponent times the lower monomial's weight.
    function automatic logic [PW+1:0] scale(input logic [PW-1:0] w, input logic [1:0] e);
        case (e)
            2'd1:    return (PW + 2)'(w);
            2'd2:    return (PW + 2)'(w) << 1;
            2'd3:    return ((PW + 2)'(w) << 1) + (PW + 2)'(w);
            default: return '0;
        endcase
    endfunction

    assign last_n = i_three ? NW'(CELL3_COEFS - 1) : NW'(CELL2_COEFS - 1);
    assign o_pop  = (r_state == S_IDLE) && i_head.valid;

    // Monomial exponents of the coefficient being fetched.
    always_comb begin
        if (i_three) begin
            i0 = r_n[5:4];
            j0 = r_n[3:2];
            k0 = r_n[1:0];
        end else begin
            i0 = r_n[3:2];
            j0 = r_n[1:0];
            k0 = 2'd0;
        end
    end

    assign mem_we   = o_pop && !i_head.is_eval && i_head.wr_ok;
    assign mem_re   = (r_state == S_RUN);
    assign mem_addr = (r_state == S_IDLE) ? i_h_waddr
                    : ((AW'(r_cidx) << (i_three ? 6 : 4)) + AW'(r_n));

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= i_h_wdata;
        end else if (mem_re) begin
            r_rdata <= mem[mem_addr];
        end
    end

    assign load_out = (r_state == S_DONE) && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r1_v        <= 1'b0;
            r2_v        <= 1'b0;
            r3_v        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r1_v <= (r_state == S_RUN);
            r2_v <= r1_v;
            r3_v <= r2_v;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid && i_head.is_eval) begin
                        r_state <= S_P2;
                    end
                end
                S_P2: begin
                    r_n     <= '0;
                    r_state <= S_P3;
                end
                S_P3: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_n <= r_n + NW'(1);
                    if (r_n == last_n) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (r3_v && r3_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (load_out) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Setup: latch the split point, then square and cube the fractions and
    // form the linear cell index in the S_P2 and S_P3 states.
    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.is_eval) begin
            r_xc  <= i_h_xc;
            r_yc  <= i_h_yc;
            r_zc  <= i_h_zc;
            r_px1 <= PW'(i_h_fx);
            r_py1 <= PW'(i_h_fy);
            r_pz1 <= PW'(i_h_fz);
        end
        if (r_state == S_P2) begin
            r_px2 <= fmul(r_px1, r_px1);
            r_py2 <= fmul(r_py1, r_py1);
            r_pz2 <= fmul(r_pz1, r_pz1);
            r_xny <= CIW'(r_xc) * CIW'(i_ny);
        end
        if (r_state == S_P3) begin
            r_px3  <= fmul(r_px2, r_px1);
            r_py3  <= fmul(r_py2, r_py1);
            r_pz3  <= fmul(r_pz2, r_pz1);
            r_cidx <= (r_xny + CIW'(r_yc)) * CIW'(i_nz) + CIW'(r_zc);
        end
    end

    // Pipeline: xy products, then times the z power, then times the
    // coefficient, then accumulate.
    always_ff @(posedge i_clk) begin
        r1_last <= (r_n == last_n);
        r1_i    <= i0;
        r1_j    <= j0;
        r1_k    <= k0;
        r1_pxy  <= fmul(pick(i0, r_px1, r_px2, r_px3), pick(j0, r_py1, r_py2, r_py3));
        r1_pxyx <= (i0 != 2'd0)
                 ? fmul(pick(i0 - 2'd1, r_px1, r_px2, r_px3), pick(j0, r_py1, r_py2, r_py3))
                 : '0;
        r1_pxyy <= (j0 != 2'd0)
                 ? fmul(pick(i0, r_px1, r_px2, r_px3), pick(j0 - 2'd1, r_py1, r_py2, r_py3))
                 : '0;

        r2_last <= r1_last;
        r2_i    <= r1_i;
        r2_j    <= r1_j;
        r2_k    <= r1_k;
        r2_c    <= r_rdata;
        r2_w    <= fmul(r1_pxy, pick(r1_k, r_pz1, r_pz2, r_pz3));
        r2_wx   <= fmul(r1_pxyx, pick(r1_k, r_pz1, r_pz2, r_pz3));
        r2_wy   <= fmul(r1_pxyy, pick(r1_k, r_pz1, r_pz2, r_pz3));
        r2_wz   <= (r1_k != 2'd0) ? fmul(r1_pxy, pick(r1_k - 2'd1, r_pz1, r_pz2, r_pz3)) : '0;

        r3_last <= r2_last;
        r3_pv   <= $signed(r2_c) * $signed({3'b000, r2_w});
        r3_px   <= $signed(r2_c) * $signed({1'b0, scale(r2_wx, r2_i)});
        r3_py   <= $signed(r2_c) * $signed({1'b0, scale(r2_wy, r2_j)});
        r3_pz   <= $signed(r2_c) * $signed({1'b0, scale(r2_wz, r2_k)});

        if (r_state == S_P2) begin
            r_acc_v <= '0;
            r_acc_x <= '0;
            r_acc_y <= '0;
            r_acc_z <= '0;
        end else if (r3_v) begin
            r_acc_v <= r_acc_v + ACC_W'(r3_pv);
            r_acc_x <= r_acc_x + ACC_W'(r3_px);
            r_acc_y <= r_acc_y + ACC_W'(r3_py);
            r_acc_z <= r_acc_z + ACC_W'(r3_pz);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            o_spline_value <= finish_sum(r_acc_v);
            o_grad_x       <= finish_sum(r_acc_x);
            o_grad_y       <= finish_sum(r_acc_y);
            o_grad_z       <= finish_sum(r_acc_z);
        end
    end

    assign o_valid = r_out_valid;

endmodule

// ===== rtl/core/tricubic_spline_evaluator_top.sv =====
// Top level of the tricubic spline evaluator: front end, job queue, back end.
// Depends on tse_pkg, tse_front and tse_back.
//
// Usage: the input channel (i_valid/o_ready) takes one item per handshake.
// A write item (opcode 0) stores i_coef_value at i_coef_addr and gives no
// result; an evaluate item (opcode 1) gives one result on the output channel
// (o_valid/i_ready): the spline value and its x, y and z gradients.
// A write item is stored as the back end takes it from the queue. An
// evaluate item reads the coefficients of its cell, 64 in tricubic and
// 16 in bicubic mode; the rate is set by the single-port coefficient memory,
// which delivers one coefficient of the cell per cycle to the four
// accumulators. A two-entry queue lets items be accepted while the back end
// is busy. When the receiver stalls, the finished result holds in the output
// register, the next evaluation runs to completion and waits, and the queue
// then fills and drops o_ready. Reset empties the queue and the pipeline and
// sets tricubic mode with 16 cells per axis; the coefficient memory is not
// cleared and must be written before use. Configuration must be written via
// i_cfg_we/i_cfg_idx/i_cfg_data only while the block is idle; not enforced.
module tricubic_spline_evaluator_top #(
    parameter int MAX_CELLS_PER_AXIS = tse_pkg::MAX_CELLS_DEF,
    parameter int COEF_WORDS         = tse_pkg::COEF_WORDS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_opcode,
    input  logic [tse_pkg::ADDR_IN_W-1:0]          i_coef_addr,
    input  logic signed [tse_pkg::COEF_W-1:0]      i_coef_value,
    input  logic signed [tse_pkg::POS_W-1:0]       i_pos_x,
    input  logic signed [tse_pkg::POS_W-1:0]       i_pos_y,
    input  logic signed [tse_pkg::POS_W-1:0]       i_pos_z,
    input  logic                                   i_cfg_we,
    input  logic [tse_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [tse_pkg::CFG_W-1:0]              i_cfg_data,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [tse_pkg::OUT_W-1:0]       o_spline_value,
    output logic signed [tse_pkg::OUT_W-1:0]       o_grad_x,
    output logic signed [tse_pkg::OUT_W-1:0]       o_grad_y,
    output logic signed [tse_pkg::OUT_W-1:0]       o_grad_z
);
    import tse_pkg::*;

    localparam int CW = $clog2(MAX_CELLS_PER_AXIS + 1);
    localparam int AW = $clog2(COEF_WORDS);

    t_head              head;
    logic [AW-1:0]      h_waddr;
    logic [COEF_W-1:0]  h_wdata;
    logic [CW-1:0]      h_xc, h_yc, h_zc;
    logic [FRAC_BITS-1:0] h_fx, h_fy, h_fz;
    logic               three;
    logic [CW-1:0]      ny, nz;
    logic               pop;

    tse_front #(
        .MAX_CELLS  (MAX_CELLS_PER_AXIS),
        .COEF_WORDS (COEF_WORDS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_opcode     (i_opcode),
        .i_coef_addr  (i_coef_addr),
        .i_coef_value (i_coef_value),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_pop        (pop),
        .o_head       (head),
        .o_h_waddr    (h_waddr),
        .o_h_wdata    (h_wdata),
        .o_h_xc       (h_xc),
        .o_h_yc       (h_yc),
        .o_h_zc       (h_zc),
        .o_h_fx       (h_fx),
        .o_h_fy       (h_fy),
        .o_h_fz       (h_fz),
        .o_three      (three),
        .o_ny         (ny),
        .o_nz         (nz)
    );

    tse_back #(
        .MAX_CELLS  (MAX_CELLS_PER_AXIS),
        .COEF_WORDS (COEF_WORDS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_h_waddr      (h_waddr),
        .i_h_wdata      (h_wdata),
        .i_h_xc         (h_xc),
        .i_h_yc         (h_yc),
        .i_h_zc         (h_zc),
        .i_h_fx         (h_fx),
        .i_h_fy         (h_fy),
        .i_h_fz         (h_fz),
        .i_three        (three),
        .i_ny           (ny),
        .i_nz           (nz),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_spline_value (o_spline_value),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_grad_z       (o_grad_z)
    );

endmodule

// ===== rtl/core/tse_checker.sv =====
// Port-level checker for the tricubic spline evaluator, bound to the top level.
// Depends on tse_pkg and tricubic_spline_evaluator_top_macros.svh.
`include "tricubic_spline_evaluator_top_macros.svh"

module tse_checker (
    input logic                                   i_clk,
    input logic                                   i_rst_n,
    input logic                                   i_cfg_we,
    input logic [tse_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input logic [tse_pkg::CFG_W-1:0]              i_cfg_data,
    input logic                                   o_valid,
    input logic                                   i_ready,
    input logic signed [tse_pkg::OUT_W-1:0]       o_spline_value,
    input logic signed [tse_pkg::OUT_W-1:0]       o_grad_z
);
    import tse_pkg::*;

    logic r_three;

    // Shadow of the mode register, as seen on the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_three <= 1'b1;
        end else if (i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_THREE_D)) begin
            r_three <= i_cfg_data[0];
        end
    end

    `TSE_ASSERT_ALWAYS(a_reset_clears_out, !i_rst_n, !o_valid, "result valid right after reset")
    `TSE_ASSERT_NEXT(a_out_held, o_valid && !i_ready, o_valid, "result dropped while stalled")
    `TSE_ASSERT_NEXT(a_out_stable, o_valid && !i_ready, $stable(o_spline_value), "value changed while stalled")
    `TSE_ASSERT_SAME(a_grad_z_2d, o_valid && !r_three, o_grad_z == '0, "z gradient nonzero in bicubic mode")

endmodule

bind tricubic_spline_evaluator_top tse_checker u_tse_checker (.*);

// ===== sim/tricubic_spline_evaluator_top_tb.sv =====
// Self-checking testbench for tricubic_spline_evaluator_top.
// Depends on tse_pkg and the block's RTL; holds its own spline predictor.
`timescale 1ns / 1ps

module tricubic_spline_evaluator_top_tb;
    import tse_pkg::*;

    localparam int  STORE_WORDS = 262144;
    localparam int  CYCLE_LIMIT = 3000000;
    localparam int  SETTLE      = 120;
    localparam longint ONE      = 64'd65536;

    typedef struct packed {
        logic signed [OUT_W-1:0] value;
        logic signed [OUT_W-1:0] gx;
        logic signed [OUT_W-1:0] gy;
        logic signed [OUT_W-1:0] gz;
    } spline_res_t;

    typedef struct {
        t_op                   op;
        logic [ADDR_IN_W-1:0]  addr;
        logic [COEF_W-1:0]     coef;
        logic [POS_W-1:0]      x;
        logic [POS_W-1:0]      y;
        logic [POS_W-1:0]      z;
        bit                    typed;
        spline_res_t           res;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_opcode = 1'b0;
    logic [ADDR_IN_W-1:0] i_coef_addr = '0;
    logic signed [COEF_W-1:0] i_coef_value = '0;
    logic signed [POS_W-1:0] i_pos_x = '0;
    logic signed [POS_W-1:0] i_pos_y = '0;
    logic signed [POS_W-1:0] i_pos_z = '0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic signed [OUT_W-1:0] o_spline_value;
    logic signed [OUT_W-1:0] o_grad_x;
    logic signed [OUT_W-1:0] o_grad_y;
    logic signed [OUT_W-1:0] o_grad_z;

    tricubic_spline_evaluator_top DUT (.*);

    always #2 i_clk = ~i_clk;

    // Shadow of the block's state.
    logic [COEF_W-1:0] coef_mem [STORE_WORDS];
    bit                coef_written [STORE_WORDS];
    logic              mode_3d;
    logic [CFG_W-1:0]  ncells [3];

    spline_res_t pending_results [$];
    int  errors = 0;
    int  cycles = 0;
    int  items_sent = 0;
    bit  calm = 0;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint eff_cells(logic [CFG_W-1:0] r);
        if (r == 0) return 1;
        if (r > 16) return 16;
        return longint'(r);
    endfunction

    // Clamp one coordinate and split it into cell index and fraction.
    function automatic void split_coord(input logic signed [POS_W-1:0] raw, input longint n,
                                        output longint cell_no, output longint frac);
        longint p;
        p = longint'(raw);
        if (p < 0) p = 0;
        if (p > (n << FRAC_BITS)) p = n << FRAC_BITS;
        cell_no = p >> FRAC_BITS;
        frac = p - (cell_no << FRAC_BITS);
        if (cell_no >= n) cell_no = n - 1;
    endfunction

    function automatic void locate_cell(input logic [POS_W-1:0] x, y, z,
                                        output longint base, output int count,
                                        output longint fx, fy, fz);
        longint nx, ny, nz, xc, yc, zc;
        nx = eff_cells(ncells[0]);
        ny = eff_cells(ncells[1]);
        nz = mode_3d ? eff_cells(ncells[2]) : 1;
        split_coord(x, nx, xc, fx);
        split_coord(y, ny, yc, fy);
        zc = 0;
        fz = 0;
        if (mode_3d) split_coord(z, nz, zc, fz);
        if (mode_3d) begin
            base = (xc * ny * nz + yc * nz + zc) * 64;
            count = CELL3_COEFS;
        end else begin
            base = (xc * ny + yc) * 16;
            count = CELL2_COEFS;
        end
    endfunction

    function automatic logic signed [OUT_W-1:0] round_sat(longint s);
        longint r;
        r = s >>> FRAC_BITS;
        if (r > 64'sh7FFF_FFFF_FFFF) r = 64'sh7FFF_FFFF_FFFF;
        if (r < -64'sh8000_0000_0000) r = -64'sh8000_0000_0000;
        return r[OUT_W-1:0];
    endfunction

    function automatic spline_res_t predict_spline(logic [POS_W-1:0] x, y, z);
        longint base, fx, fy, fz, c, sv, sgx, sgy, sgz;
        longint px [4];
        longint py [4];
        longint pz [4];
        longint w [4][4][4];
        int count, kdim, n;
        spline_res_t r;
        locate_cell(x, y, z, base, count, fx, fy, fz);
        px[0] = ONE; py[0] = ONE; pz[0] = ONE;
        px[1] = fx;  py[1] = fy;  pz[1] = fz;
        for (int p = 2; p < 4; p++) begin
            px[p] = (px[p-1] * fx) >> FRAC_BITS;
            py[p] = (py[p-1] * fy) >> FRAC_BITS;
            pz[p] = (pz[p-1] * fz) >> FRAC_BITS;
        end
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                for (int k = 0; k < 4; k++)
                    w[i][j][k] = (((px[i] * py[j]) >> FRAC_BITS) * pz[k]) >> FRAC_BITS;
        kdim = mode_3d ? 4 : 1;
        sv = 0; sgx = 0; sgy = 0; sgz = 0;
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                for (int k = 0; k < kdim; k++) begin
                    n = i * 4 * kdim + j * kdim + k;
                    c = longint'($signed(coef_mem[(base + n) % STORE_WORDS]));
                    sv += c * w[i][j][k];
                    if (i > 0) sgx += c * (i * w[i-1][j][k]);
                    if (j > 0) sgy += c * (j * w[i][j-1][k]);
                    if (k > 0) sgz += c * (k * w[i][j][k-1]);
                end
        r.value = round_sat(sv);
        r.gx = round_sat(sgx);
        r.gy = round_sat(sgy);
        r.gz = round_sat(sgz);
        return r;
    endfunction

    task automatic send_item(input stim_row_t row);
        if (!calm && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end else begin
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= row.op;
        i_coef_addr <= row.addr;
        i_coef_value <= row.coef;
        i_pos_x <= row.x;
        i_pos_y <= row.y;
        i_pos_z <= row.z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
        if (row.op == OP_WRITE) begin
            coef_mem[row.addr] = row.coef;
            coef_written[row.addr] = 1;
        end else if (row.typed) begin
            pending_results.push_back(row.res);
        end else begin
            pending_results.push_back(predict_spline(row.x, row.y, row.z));
        end
    endtask

    task automatic send_write(input logic [ADDR_IN_W-1:0] a, input logic [COEF_W-1:0] v);
        stim_row_t row;
        row = '{OP_WRITE, a, v, '0, '0, '0, 0, '0};
        send_item(row);
    endtask

    // Any coefficient of the target cell that was never stored gets a value first.
    task automatic send_eval(input logic [POS_W-1:0] x, y, z);
        longint base, fx, fy, fz;
        int count;
        stim_row_t row;
        locate_cell(x, y, z, base, count, fx, fy, fz);
        for (int n = 0; n < count; n++)
            if (!coef_written[base + n])
                send_write(ADDR_IN_W'(base + n), ($urandom_range(0, 1) != 0) ? $urandom :
                           $urandom_range(0, 32'h3_FFFF) - 32'h2_0000);
        row = '{OP_EVAL, ADDR_IN_W'($urandom), $urandom, x, y, z, 0, '0};
        send_item(row);
    endtask

    // The last accepted item must not stay offered while the sender waits.
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic set_config(input logic d3, input logic [CFG_W-1:0] cx, cy, cz);
        logic [CFG_W-1:0] vals [4];
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        vals[0] = {4'b0, d3};
        vals[1] = cx;
        vals[2] = cy;
        vals[3] = cz;
        for (int r = 0; r < 4; r++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= t_cfg_idx'(r);
            i_cfg_data <= vals[r];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        mode_3d = d3;
        ncells[0] = cx;
        ncells[1] = cy;
        ncells[2] = cz;
    endtask

    function automatic logic [POS_W-1:0] rand_coord(int axis);
        case ($urandom_range(0, 9))
            7: return POS_W'($urandom);
            8: return POS_W'(eff_cells(ncells[axis]) << FRAC_BITS);
            9: return -POS_W'($urandom_range(1, 200000));
            default: return POS_W'($urandom_range(0, 131072));
        endcase
    endfunction

    // Receiver side: random stall bursts until the calm tail of the run.
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        spline_res_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: %h %h %h %h", $realtime,
                         o_spline_value, o_grad_x, o_grad_y, o_grad_z);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_spline_value !== want.value) begin
                    $display("%0t: value exp %0d got %0d", $realtime, want.value,
                             o_spline_value);
                    errors++;
                end
                if (o_grad_x !== want.gx) begin
                    $display("%0t: grad_x exp %0d got %0d", $realtime, want.gx, o_grad_x);
                    errors++;
                end
                if (o_grad_y !== want.gy) begin
                    $display("%0t: grad_y exp %0d got %0d", $realtime, want.gy, o_grad_y);
                    errors++;
                end
                if (o_grad_z !== want.gz) begin
                    $display("%0t: grad_z exp %0d got %0d", $realtime, want.gz, o_grad_z);
                    errors++;
                end
            end
        end
    end

    initial begin
        stim_row_t directed [$];
        spline_res_t unit;
        int phase_end;
        mode_3d = 1'b1;
        ncells[0] = 16;
        ncells[1] = 16;
        ncells[2] = 16;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part in bicubic mode with one cell. Until word 15 is written only
        // the constant term is one: value one, every gradient zero wherever we land.
        set_config(1'b0, 5'd1, 5'd1, 5'd1);
        unit = '{48'sd65536, '0, '0, '0};
        for (int n = 0; n < 16; n++)
            directed.push_back('{OP_WRITE, ADDR_IN_W'(n), (n == 0) ? 32'h0001_0000 : 32'h0,
                                 '0, '0, '0, 0, '0});
        directed.push_back('{OP_EVAL, '0, '0, 22'd0, 22'd0, 22'd0, 1, unit});
        directed.push_back('{OP_EVAL, '0, '0, 22'h20_0000, 22'h20_0000, 22'h20_0000, 1, unit});
        directed.push_back('{OP_EVAL, '0, '0, 22'h1_0000, 22'h1_0000, 22'h0, 1, unit});
        directed.push_back('{OP_EVAL, '0, '0, 22'h1F_FFFF, 22'h1F_FFFF, 22'h1F_FFFF, 1, unit});
        directed.push_back('{OP_WRITE, 18'd15, 32'h7FFF_FFFF, '0, '0, '0, 0, '0});
        directed.push_back('{OP_EVAL, '0, '0, 22'h0_8000, 22'h0_C000, 22'h0, 0, '0});
        directed.push_back('{OP_WRITE, 18'd5, 32'h8000_0000, '0, '0, '0, 0, '0});
        directed.push_back('{OP_EVAL, '0, '0, 22'h0_FFFF, 22'h0_0001, 22'h3F_FFFF, 0, '0});
        directed.push_back('{OP_WRITE, 18'h3_FFFF, 32'hFFFF_FFFF, '0, '0, '0, 0, '0});
        foreach (directed[i]) send_item(directed[i]);

        // Random phases through several register settings, the extremes among them.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_config(1'b1, 5'd16, 5'd16, 5'd16);
                1: set_config(1'b0, 5'd16, 5'd16, 5'd31);
                2: set_config(1'b1, 5'd0, 5'd31, 5'd3);
                3: set_config(1'b1, 5'd3, 5'd2, 5'd5);
                4: set_config(1'b0, 5'd5, 5'd0, 5'd0);
                default: set_config(1'b1, 5'd1, 5'd1, 5'd1);
            endcase
            phase_end = items_sent + 215;
            if (ph == 5) calm = 1;
            while (items_sent < phase_end) begin
                if (ph == 2 && items_sent > phase_end - 100 && items_sent < phase_end - 90)
                    wait_drained();
                if ($urandom_range(0, 4) == 0)
                    send_write(ADDR_IN_W'($urandom), $urandom);
                else
                    send_eval(rand_coord(0), rand_coord(1), rand_coord(2));
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        wait_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
